// ===== design/assert_macros.svh =====
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define GRRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is asserted
`define GRRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/grrd_pkg.sv =====
package grrd_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int HDR_BITS    = 5;
    localparam int MAX_RESULTS = 30;

    // error codes carried with each result
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_ZERO_COUNT = 2'd1;
    localparam logic [1:0] ERR_EARLY_END  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMPTY,
        S_BITS,
        S_EMIT,
        S_EOD,
        S_CLOSE
    } t_state;

    // result side-band, row bits travel separately
    typedef struct packed {
        logic [1:0] error_kind;
        logic       glyph_done;
        logic       row_valid;
        logic [6:0] row_number;
    } t_info;

    // decode core to output stage
    typedef struct packed {
        logic  push;
        logic  close;
        logic  set_err;
        t_info info;
    } t_cmd;

    // decode core to row assembler
    typedef struct packed {
        logic       clr;
        logic       wr;
        logic       din;
        logic [6:0] pos;
    } t_row_ctl;

endpackage

// ===== design/grrd_row_asm.sv =====
module grrd_row_asm #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                    i_clk,
    input  grrd_pkg::t_row_ctl      i_ctl,
    output logic [MAX_WIDTH-1:0]    o_row
);
    import grrd_pkg::*;

    logic [MAX_WIDTH-1:0] r_row;

    // each pixel flop loads the serial bit when the position counter points at it
    for (genvar x = 0; x < MAX_WIDTH; x++) begin : g_pix
        always_ff @(posedge i_clk) begin
            if (i_ctl.clr) begin
                r_row[x] <= 1'b0;
            end else if (i_ctl.wr && (i_ctl.pos == 7'(x))) begin
                r_row[x] <= i_ctl.din;
            end
        end
    end

    assign o_row = r_row;

endmodule

// ===== design/grrd_core.sv =====
module grrd_core #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_byte,
    input  logic                i_start,
    input  logic [6:0]          i_width,
    input  logic [6:0]          i_height,
    input  logic                i_eod,
    output grrd_pkg::t_cmd      o_cmd,
    input  logic                i_cmd_ready,
    output grrd_pkg::t_row_ctl  o_row
);
    import grrd_pkg::*;

    localparam logic [6:0] WIDTH_CAP = 7'(MAX_WIDTH);

    t_state      r_state, n_state;
    logic [7:0]  r_byte, n_byte;
    logic [3:0]  r_bitcnt, n_bitcnt;
    logic        r_eod, n_eod;
    logic [6:0]  r_width, n_width;
    logic [6:0]  r_height, n_height;
    logic [6:0]  r_rows_done, n_rows_done;
    logic [3:0]  r_hs, n_hs;
    logic [2:0]  r_hseen, n_hseen;
    logic        r_in_row, n_in_row;
    logic        r_distinct, n_distinct;
    logic [3:0]  r_rem, n_rem;
    logic [6:0]  r_pos, n_pos;
    logic        r_active, n_active;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_set_err, n_set_err;

    logic [4:0]  w_hdr;
    logic [6:0]  w_pos_inc;
    logic        w_last_row;

    assign w_hdr      = {r_byte[0], r_hs};
    assign w_pos_inc  = r_pos + 7'd1;
    assign w_last_row = (r_rows_done + 7'd1) >= r_height;

    always_comb begin
        n_state     = r_state;
        n_byte      = r_byte;
        n_bitcnt    = r_bitcnt;
        n_eod       = r_eod;
        n_width     = r_width;
        n_height    = r_height;
        n_rows_done = r_rows_done;
        n_hs        = r_hs;
        n_hseen     = r_hseen;
        n_in_row    = r_in_row;
        n_distinct  = r_distinct;
        n_rem       = r_rem;
        n_pos       = r_pos;
        n_active    = r_active;
        n_cnt       = r_cnt;
        n_set_err   = r_set_err;
        o_ready     = 1'b0;
        o_cmd       = '0;
        o_row       = '0;
        o_row.pos   = r_pos;
        o_row.din   = r_byte[0];

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_byte    = i_byte;
                    n_eod     = i_eod;
                    n_bitcnt  = '0;
                    n_cnt     = '0;
                    n_set_err = 1'b0;
                    n_state   = S_BITS;
                    if (i_start) begin
                        n_width     = (i_width > WIDTH_CAP) ? WIDTH_CAP : i_width;
                        n_height    = i_height;
                        n_rows_done = '0;
                        n_hseen     = '0;
                        n_in_row    = 1'b0;
                        n_distinct  = 1'b0;
                        n_rem       = '0;
                        n_pos       = '0;
                        o_row.clr   = 1'b1;
                        if (i_width == 7'd0 || i_height == 7'd0) begin
                            n_active = 1'b0;
                            n_state  = S_EMPTY;
                        end else begin
                            n_active = 1'b1;
                        end
                    end
                end
            end

            S_EMPTY: begin
                o_cmd.push            = 1'b1;
                o_cmd.info.glyph_done = 1'b1;
                if (i_cmd_ready) begin
                    n_cnt   = r_cnt + 5'd1;
                    n_state = S_BITS;
                end
            end

            S_BITS: begin
                if (!r_active || r_bitcnt == 4'(BYTE_BITS)) begin
                    n_state = S_EOD;
                end else if (!r_in_row) begin
                    if (r_hseen == 3'(HDR_BITS - 1)) begin
                        if (w_hdr[4:1] == 4'd0) begin
                            // zero group count ends the glyph
                            o_cmd.push            = 1'b1;
                            o_cmd.info.error_kind = ERR_ZERO_COUNT;
                            if (i_cmd_ready) begin
                                n_cnt    = r_cnt + 5'd1;
                                n_active = 1'b0;
                                n_hseen  = '0;
                                n_byte   = r_byte >> 1;
                                n_bitcnt = r_bitcnt + 4'd1;
                            end
                        end else begin
                            n_distinct = w_hdr[0];
                            n_rem      = w_hdr[4:1];
                            n_in_row   = 1'b1;
                            n_pos      = '0;
                            n_hseen    = '0;
                            n_byte     = r_byte >> 1;
                            n_bitcnt   = r_bitcnt + 4'd1;
                        end
                    end else begin
                        n_hs     = {r_byte[0], r_hs[3:1]};
                        n_hseen  = r_hseen + 3'd1;
                        n_byte   = r_byte >> 1;
                        n_bitcnt = r_bitcnt + 4'd1;
                    end
                end else begin
                    o_row.wr = 1'b1;
                    n_byte   = r_byte >> 1;
                    n_bitcnt = r_bitcnt + 4'd1;
                    if (w_pos_inc >= r_width) begin
                        n_pos   = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_pos = w_pos_inc;
                    end
                end
            end

            S_EMIT: begin
                if (r_distinct) begin
                    o_cmd.push            = 1'b1;
                    o_cmd.info.row_valid  = 1'b1;
                    o_cmd.info.row_number = r_rows_done;
                    o_cmd.info.glyph_done = w_last_row;
                    if (i_cmd_ready) begin
                        n_cnt       = r_cnt + 5'd1;
                        n_rows_done = r_rows_done + 7'd1;
                        n_rem       = r_rem - 4'd1;
                        o_row.clr   = 1'b1;
                        n_state     = S_BITS;
                        if (w_last_row) begin
                            n_active = 1'b0;
                        end
                        if (r_rem == 4'd1) begin
                            n_in_row = 1'b0;
                        end
                    end
                end else if (r_rem != 4'd0 && r_active) begin
                    // repeat group: same row, one beat per cycle while the output stage takes it
                    o_cmd.push            = 1'b1;
                    o_cmd.info.row_valid  = 1'b1;
                    o_cmd.info.row_number = r_rows_done;
                    o_cmd.info.glyph_done = w_last_row;
                    if (i_cmd_ready) begin
                        n_cnt       = r_cnt + 5'd1;
                        n_rows_done = r_rows_done + 7'd1;
                        n_rem       = r_rem - 4'd1;
                        if (w_last_row) begin
                            n_active = 1'b0;
                        end
                    end
                end else begin
                    n_rem     = '0;
                    o_row.clr = 1'b1;
                    n_in_row  = 1'b0;
                    n_state   = S_BITS;
                end
            end

            S_EOD: begin
                n_state = S_CLOSE;
                if (r_active && r_eod) begin
                    if (r_cnt == 5'(MAX_RESULTS)) begin
                        // no room for another beat, flag the last one instead
                        n_active  = 1'b0;
                        n_set_err = 1'b1;
                    end else begin
                        o_cmd.push            = 1'b1;
                        o_cmd.info.error_kind = ERR_EARLY_END;
                        if (i_cmd_ready) begin
                            n_active = 1'b0;
                            n_cnt    = r_cnt + 5'd1;
                        end else begin
                            n_state = S_EOD;
                        end
                    end
                end
            end

            S_CLOSE: begin
                o_cmd.close   = 1'b1;
                o_cmd.set_err = r_set_err;
                if (i_cmd_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_in_row <= 1'b0;
            r_hseen  <= '0;
            r_bitcnt <= '0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_in_row <= n_in_row;
            r_hseen  <= n_hseen;
            r_bitcnt <= n_bitcnt;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte      <= n_byte;
        r_eod       <= n_eod;
        r_width     <= n_width;
        r_height    <= n_height;
        r_rows_done <= n_rows_done;
        r_hs        <= n_hs;
        r_distinct  <= n_distinct;
        r_rem       <= n_rem;
        r_pos       <= n_pos;
        r_set_err   <= n_set_err;
    end

endmodule

// ===== design/grrd_out_stage.sv =====
module grrd_out_stage #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  grrd_pkg::t_cmd        i_cmd,
    output logic                  o_cmd_ready,
    input  logic [MAX_WIDTH-1:0]  i_row_bits,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [MAX_WIDTH-1:0]  o_bits,
    output grrd_pkg::t_info       o_info,
    output logic                  o_last
);
    import grrd_pkg::*;

    // one result is held back until we know whether another follows it
    logic                 r_p_valid;
    logic [MAX_WIDTH-1:0] r_p_bits;
    t_info                r_p_info;
    logic                 r_o_valid;
    logic [MAX_WIDTH-1:0] r_o_bits;
    t_info                r_o_info;
    logic                 r_o_last;

    logic  w_out_free;
    logic  w_take;
    logic  w_move;
    t_info w_move_info;

    assign w_out_free  = !r_o_valid || i_ready;
    assign o_cmd_ready = !r_p_valid || w_out_free;
    assign w_take      = i_cmd.push && o_cmd_ready;
    assign w_move      = r_p_valid && w_out_free && (i_cmd.push || i_cmd.close);

    // early end of data is folded into the final beat when no room is left
    always_comb begin
        w_move_info = r_p_info;
        if (i_cmd.close && i_cmd.set_err) begin
            w_move_info.error_kind = ERR_EARLY_END;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_p_valid <= 1'b1;
            end else if (i_cmd.close && o_cmd_ready) begin
                r_p_valid <= 1'b0;
            end
            if (w_move) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_o_bits <= r_p_bits;
            r_o_info <= w_move_info;
            r_o_last <= i_cmd.close;
        end
        if (w_take) begin
            r_p_bits <= i_cmd.info.row_valid ? i_row_bits : '0;
            r_p_info <= i_cmd.info;
        end
    end

    assign o_valid = r_o_valid;
    assign o_bits  = r_o_bits;
    assign o_info  = r_o_info;
    assign o_last  = r_o_last;

endmodule

// ===== design/glyph_row_run_decoder.sv =====
// glyph row-run decoder: expands a glyph's compressed bitmap into pixel rows.
// input stream: one beat per byte, s_axis_tuser is glyph_start (loads width
//   and height from tdata, clears decode state), s_axis_tlast is end_of_data.
// output stream: one beat per decoded row, plus beats for an empty glyph
//   (glyph_done set) and for errors (zero group count, data ended early);
//   m_axis_tlast marks the final beat caused by an input byte.
// bits are taken lsb first, one per cycle while no beat is emitted, through
//   a byte shift register, a 4-bit header shift register and a pixel-serial
//   row assembler. a byte of an open glyph passes through load, eight bit
//   steps, byte wrap-up, end-of-data check and close, plus its row beats
//   and the exit from each repeat group; once the glyph is idle the
//   leftover bit steps are skipped.
// hand-off: a beat moves to the output register when the next beat of its
//   byte is made or at the byte's close step; the final beat shows the
//   cycle after the close step
// reset: synchronous, active low; the decoder idles until a glyph_start beat.
// stall: one result is held pending and one sits in the output register;
//   when both are full the decoder waits in place, no beat is lost.
module glyph_row_run_decoder #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // data_byte[7:0], glyph_width[14:8], glyph_height[21:15], zero pad
    input  logic [23:0]                            s_axis_tdata,
    // glyph_start
    input  logic                                   s_axis_tuser,
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // row_bits[MAX_WIDTH-1:0], row_number[MAX_WIDTH+6:MAX_WIDTH], zero pad
    output logic [((MAX_WIDTH + 7 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // row_valid[0], glyph_done[1], error_kind[3:2]
    output logic [3:0]                             m_axis_tuser,
    output logic                                   m_axis_tlast
);
    import grrd_pkg::*;

    t_cmd                 w_cmd;
    logic                 w_cmd_ready;
    t_row_ctl             w_row_ctl;
    logic [MAX_WIDTH-1:0] w_row;
    logic [MAX_WIDTH-1:0] w_out_bits;
    t_info                w_out_info;

    // bit-serial header and row decode, result sequencing
    grrd_core #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata[7:0]),
        .i_start     (s_axis_tuser),
        .i_width     (s_axis_tdata[14:8]),
        .i_height    (s_axis_tdata[21:15]),
        .i_eod       (s_axis_tlast),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready),
        .o_row       (w_row_ctl)
    );

    // pixel row built one bit per cycle during the decoder's row bit steps
    grrd_row_asm #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_row (
        .i_clk (i_clk),
        .i_ctl (w_row_ctl),
        .o_row (w_row)
    );

    // pending result plus output register
    grrd_out_stage #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .i_row_bits  (w_row),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_bits      (w_out_bits),
        .o_info      (w_out_info),
        .o_last      (m_axis_tlast)
    );

    always_comb begin
        m_axis_tdata                       = '0;
        m_axis_tdata[MAX_WIDTH-1:0]        = w_out_bits;
        m_axis_tdata[MAX_WIDTH +: 7]       = w_out_info.row_number;
    end

    assign m_axis_tuser = {w_out_info.error_kind, w_out_info.glyph_done, w_out_info.row_valid};

endmodule

// ===== design/grrd_checker.sv =====
module grrd_checker #(
    parameter int MAX_WIDTH = 64
) (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   s_axis_tvalid,
    input logic                                   s_axis_tready,
    input logic [23:0]                            s_axis_tdata,
    input logic                                   s_axis_tuser,
    input logic                                   s_axis_tlast,
    input logic                                   m_axis_tvalid,
    input logic                                   m_axis_tready,
    input logic [((MAX_WIDTH + 7 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input logic [3:0]                             m_axis_tuser,
    input logic                                   m_axis_tlast
);
    import grrd_pkg::*;
    `include "assert_macros.svh"

    localparam int OUT_W = ((MAX_WIDTH + 7 + 7) / 8) * 8;

    logic             w_stall;
    logic [OUT_W+5:0] w_beat;
    logic             w_err_beat;
    logic             w_done_beat;
    logic             w_blank;
    logic             w_zero_data;

    assign w_stall     = m_axis_tvalid && !m_axis_tready;
    assign w_beat      = {m_axis_tvalid, m_axis_tdata, m_axis_tuser, m_axis_tlast};
    assign w_err_beat  = m_axis_tvalid && (m_axis_tuser[3:2] != ERR_NONE);
    assign w_done_beat = m_axis_tvalid && m_axis_tuser[1];
    assign w_blank     = m_axis_tvalid && !m_axis_tuser[0];
    assign w_zero_data = (m_axis_tdata == '0);

    // a stalled beat stays put
    `GRRD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, $stable(w_beat), "stalled beat changed")

    // an error ends decoding of the byte
    `GRRD_ASSERT_NOW(a_err_last, i_clk, i_rst_n, w_err_beat, m_axis_tlast, "error beat not last")

    // nothing follows the glyph's final row within the byte
    `GRRD_ASSERT_NOW(a_done_last, i_clk, i_rst_n, w_done_beat, m_axis_tlast, "done beat not last")

    // beats without a row carry a blank payload
    `GRRD_ASSERT_NOW(a_blank_payload, i_clk, i_rst_n, w_blank, w_zero_data, "blank beat has data")

endmodule

bind glyph_row_run_decoder grrd_checker #(.MAX_WIDTH(MAX_WIDTH)) u_grrd_checker (.*);
